// ----- rtl/vfct_pkg.sv -----
// vfct_pkg: shared types and constants for the frustum cull test core
// plane packing, datapath widths, query kinds, sequencer state and mac control
// no dependencies
`default_nettype none

package vfct_pkg;

  localparam int NUM_PLANES = 6;
  localparam int PLANE_REGS = 6;
  localparam int NPL        = (NUM_PLANES > PLANE_REGS) ? PLANE_REGS : NUM_PLANES;
  localparam int PIDX_W     = $clog2(PLANE_REGS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 64;

  localparam int CF_W    = 12;               // packed coefficient width
  localparam int COEF_W  = CF_W + 1;         // operand width, holds |-2048|
  localparam int CRD_W   = 24;
  localparam int EXT_W   = 23;
  localparam int D_W     = 28;
  localparam int DSHIFT  = 10;
  localparam int PROD_W  = COEF_W + CRD_W;
  localparam int ACC_W   = 42;
  localparam int TERM_W  = 3;

  localparam logic signed [COEF_W-1:0] RADIUS_SCALE = COEF_W'(1024);

  typedef enum logic [1:0] {
    REQ_POINT  = 2'd0,
    REQ_SPHERE = 2'd1,
    REQ_BOX    = 2'd2,
    REQ_BOX_ALT = 2'd3
  } req_type_t;

  localparam logic [TERM_W-1:0] TERM_AX = 3'd0;
  localparam logic [TERM_W-1:0] TERM_BY = 3'd1;
  localparam logic [TERM_W-1:0] TERM_CZ = 3'd2;
  localparam logic [TERM_W-1:0] TERM_EX = 3'd3;
  localparam logic [TERM_W-1:0] TERM_EY = 3'd4;
  localparam logic [TERM_W-1:0] TERM_EZ = 3'd5;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic en;     // accumulate this cycle
    logic first;  // first term of a plane: start from the offset
  } mac_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/vfct_mac.sv -----
// vfct_mac: shared multiply-accumulate unit for the plane evaluation
// one signed product per cycle, while ctl.en is high, added to the running plane value
// depends on vfct_pkg
`default_nettype none

module vfct_mac import vfct_pkg::*; (
  input  wire                            clk,
  input  wire mac_ctl_t                  ctl,
  input  wire logic signed [COEF_W-1:0]  coef,
  input  wire logic signed [CRD_W-1:0]   data,
  input  wire logic signed [D_W-1:0]     dbias,
  output logic signed [ACC_W-1:0]        sum
);

  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  base;

  assign prod = coef * data;

  // offset d carries 8 fraction bits, products 18
  assign base = ctl.first
      ? $signed({{(ACC_W-D_W-DSHIFT){dbias[D_W-1]}}, dbias, {DSHIFT{1'b0}}})
      : acc_r;

  assign sum = base + $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= sum;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/view_frustum_cull_test_core.sv -----
// view_frustum_cull_test_core: six-plane frustum test for points, spheres, boxes
// sequencer, plane registers and config port; uses vfct_mac and vfct_pkg
//
// usage
//   config: cfg_valid/cfg_ready write cfg_data into plane register cfg_index
//     (0 right, 1 left, 2 bottom, 3 top, 4 far, 5 near); cfg_ready is always
//     high and indexes six and seven are dropped. write only while not busy.
//   request: taken at a clock edge with start high and busy low. busy stays
//     high while the request is evaluated.
//   result: out_valid is high for exactly one cycle with out_inside_res;
//     the receiver cannot stall, it must take the result in that cycle.
//   timing: one multiply-accumulate step per cycle in the shared mac unit.
//     a plane takes 3 steps for a point, 4 for a sphere, 6 for a box; a
//     request runs them for each plane tested (evaluation stops at the
//     first plane that rejects). the result appears the cycle after the
//     last step; a new request may be taken in that cycle. busy lasts
//     longest for a box that passes all six planes.
//   reset: rst_n low clears all planes to zero and returns to idle.
`default_nettype none

module view_frustum_cull_test_core import vfct_pkg::*; (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire logic [1:0]              in_req_type,
  input  wire logic signed [CRD_W-1:0] in_center_x,
  input  wire logic signed [CRD_W-1:0] in_center_y,
  input  wire logic signed [CRD_W-1:0] in_center_z,
  input  wire logic [EXT_W-1:0]        in_extent_x,
  input  wire logic [EXT_W-1:0]        in_extent_y,
  input  wire logic [EXT_W-1:0]        in_extent_z,
  output logic                         out_valid,
  output logic                         out_inside_res,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data
);

  logic [CFG_W-1:0] plane_r [PLANE_REGS];

  state_t                   state_r, state_nxt;
  logic [PIDX_W-1:0]        plane_idx_r, plane_idx_nxt;
  logic [TERM_W-1:0]        term_r, term_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     inside_r, inside_nxt;

  req_type_t                type_r;
  logic signed [CRD_W-1:0]  cx_r, cy_r, cz_r;
  logic [EXT_W-1:0]         ex_r, ey_r, ez_r;

  mac_ctl_t                 mac_ctl;
  logic signed [COEF_W-1:0] coef;
  logic signed [CRD_W-1:0]  data;
  logic signed [ACC_W-1:0]  sum;

  logic [CFG_W-1:0]         plane;
  logic signed [COEF_W-1:0] ca, cb, cc, abs_a, abs_b, abs_c;
  logic signed [D_W-1:0]    dbias;
  logic                     is_box, last_term, plane_pass, accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLANE_REGS; i++) begin
        plane_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(PLANE_REGS))) begin
      plane_r[cfg_index[PIDX_W-1:0]] <= cfg_data;
    end
  end

  assign plane = plane_r[plane_idx_r];
  assign ca    = $signed({plane[11], plane[11:0]});
  assign cb    = $signed({plane[23], plane[23:12]});
  assign cc    = $signed({plane[35], plane[35:24]});
  assign dbias = $signed(plane[63:36]);
  assign abs_a = ca[COEF_W-1] ? -ca : ca;
  assign abs_b = cb[COEF_W-1] ? -cb : cb;
  assign abs_c = cc[COEF_W-1] ? -cc : cc;

  // box: best corner adds |coef|*extent per axis
  assign is_box = (type_r == REQ_BOX) || (type_r == REQ_BOX_ALT);

  always_comb begin
    coef = ca;
    data = cx_r;
    case (term_r)
      TERM_AX: begin
        coef = ca;
        data = cx_r;
      end
      TERM_BY: begin
        coef = cb;
        data = cy_r;
      end
      TERM_CZ: begin
        coef = cc;
        data = cz_r;
      end
      TERM_EX: begin
        coef = is_box ? abs_a : RADIUS_SCALE;
        data = $signed({1'b0, ex_r});
      end
      TERM_EY: begin
        coef = abs_b;
        data = $signed({1'b0, ey_r});
      end
      TERM_EZ: begin
        coef = abs_c;
        data = $signed({1'b0, ez_r});
      end
      default: begin
        coef = ca;
        data = cx_r;
      end
    endcase
  end

  always_comb begin
    case (type_r)
      REQ_POINT:  last_term = (term_r == TERM_CZ);
      REQ_SPHERE: last_term = (term_r == TERM_EX);
      default:    last_term = (term_r == TERM_EZ);
    endcase
  end

  // sphere and point need a strictly positive value, a box only non-negative
  assign plane_pass = is_box ? !sum[ACC_W-1] : (!sum[ACC_W-1] && (sum != '0));

  assign mac_ctl.en    = (state_r == ST_RUN);
  assign mac_ctl.first = (term_r == TERM_AX);

  vfct_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .coef  (coef),
    .data  (data),
    .dbias (dbias),
    .sum   (sum)
  );

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      type_r <= req_type_t'(in_req_type);
      cx_r   <= in_center_x;
      cy_r   <= in_center_y;
      cz_r   <= in_center_z;
      ex_r   <= in_extent_x;
      ey_r   <= in_extent_y;
      ez_r   <= in_extent_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      plane_idx_r <= '0;
      term_r      <= TERM_AX;
      out_valid_r <= 1'b0;
      inside_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plane_idx_r <= plane_idx_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
      inside_r    <= inside_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    plane_idx_nxt = plane_idx_r;
    term_nxt      = term_r;
    out_valid_nxt = 1'b0;
    inside_nxt    = inside_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt     = ST_RUN;
          plane_idx_nxt = '0;
          term_nxt      = TERM_AX;
        end
      end
      ST_RUN: begin
        if (!last_term) begin
          term_nxt = term_r + TERM_W'(1);
        end else if (!plane_pass) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          inside_nxt    = 1'b0;
        end else if (plane_idx_r == PIDX_W'(NPL - 1)) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          inside_nxt    = 1'b1;
        end else begin
          plane_idx_nxt = plane_idx_r + PIDX_W'(1);
          term_nxt      = TERM_AX;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy           = (state_r == ST_RUN);
  assign out_valid      = out_valid_r;
  assign out_inside_res = inside_r;

`ifndef SYNTHESIS
  a_res_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding evaluation");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted request did not raise busy");

  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still evaluating");

  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (term_r <= TERM_EZ) && (plane_idx_r < PIDX_W'(NPL)))
    else $error("sequencer step out of range");
`endif

endmodule

`default_nettype wire

// ----- bench/cull_checker.sv -----
`timescale 1ns / 100ps
// cull_checker: watches the request, result and plane-load channels of the frustum test core
// keeps its own plane copy, predicts the inside flag per request and compares in order
// depends on vfct_pkg
module cull_checker import vfct_pkg::*; (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire                          busy,
  input  wire logic [1:0]              in_req_type,
  input  wire logic signed [CRD_W-1:0] in_center_x,
  input  wire logic signed [CRD_W-1:0] in_center_y,
  input  wire logic signed [CRD_W-1:0] in_center_z,
  input  wire logic [EXT_W-1:0]        in_extent_x,
  input  wire logic [EXT_W-1:0]        in_extent_y,
  input  wire logic [EXT_W-1:0]        in_extent_z,
  input  wire                          out_valid,
  input  wire                          out_inside_res,
  input  wire                          cfg_valid,
  input  wire                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data,
  output int                           fail_count,
  output int                           pending
);

  logic [CFG_W-1:0] plane_q [PLANE_REGS];
  bit               inside_q [$];

  // plane value with 18 fraction bits
  function automatic longint plane_value(logic [CFG_W-1:0] p, longint x, longint y,
                                         longint z);
    longint a, b, c, d;
    a = longint'($signed(p[CF_W-1:0]));
    b = longint'($signed(p[2*CF_W-1:CF_W]));
    c = longint'($signed(p[3*CF_W-1:2*CF_W]));
    d = longint'($signed(p[CFG_W-1:3*CF_W]));
    return a * x + b * y + c * z + (d <<< DSHIFT);
  endfunction

  function automatic bit predict_inside(logic [1:0] kind, longint cx, longint cy,
                                        longint cz, longint ex, longint ey, longint ez);
    bit hit;
    for (int s = 0; s < NPL; s++) begin
      case (req_type_t'(kind))
        REQ_POINT: begin
          if (plane_value(plane_q[s], cx, cy, cz) <= 0) return 1'b0;
        end
        REQ_SPHERE: begin
          if (plane_value(plane_q[s], cx, cy, cz) <= -(ex <<< DSHIFT)) return 1'b0;
        end
        default: begin
          // box is culled only when all eight corners are behind the plane
          hit = 1'b0;
          for (int k = 0; k < 8; k++) begin
            if (plane_value(plane_q[s], k[0] ? cx + ex : cx - ex,
                            k[1] ? cy + ey : cy - ey,
                            k[2] ? cz + ez : cz - ez) >= 0) hit = 1'b1;
          end
          if (!hit) return 1'b0;
        end
      endcase
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    bit want;
    if (!rst_n) begin
      for (int i = 0; i < PLANE_REGS; i++) plane_q[i] = '0;
      inside_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (out_valid) begin
        if (inside_q.size() == 0) begin
          $display("%0t: inside flag with no request outstanding: expected none, actual %0b",
                   $time, out_inside_res);
          fail_count++;
        end else begin
          want = inside_q.pop_front();
          if (out_inside_res !== want) begin
            $display("%0t: inside flag wrong: expected %0b, actual %0b",
                     $time, want, out_inside_res);
            fail_count++;
          end
        end
      end
      // indexes past the plane list are dropped
      if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(PLANE_REGS)))
        plane_q[cfg_index] = cfg_data;
      if (start && !busy) begin
        inside_q.push_back(predict_inside(in_req_type, longint'(in_center_x),
                                          longint'(in_center_y), longint'(in_center_z),
                                          longint'(in_extent_x), longint'(in_extent_y),
                                          longint'(in_extent_z)));
      end
      pending <= inside_q.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for view_frustum_cull_test_core
// loads plane sets, issues point/sphere/box requests in bursts; uses cull_checker, vfct_pkg
module tb_top;
  import vfct_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int END_PAUSE   = 40;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 95;
  localparam int ONE         = 1024;  // 1.0 in Q1.10
  localparam int UNIT        = 256;   // 1.0 in Q15.8
  localparam int D_MAX       = 2**27 - 1;
  localparam int D_MIN       = -(2**27);

  localparam logic [CFG_IDX_W-1:0] REG_RIGHT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [1:0]                   in_req_type;
  logic signed [CRD_W-1:0]      in_center_x, in_center_y, in_center_z;
  logic [EXT_W-1:0]             in_extent_x, in_extent_y, in_extent_z;
  logic                         out_valid;
  logic                         out_inside_res;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_W-1:0]             cfg_data;
  int                           fail_count;
  int                           pending;
  int                           cycle_cnt = 0;
  int                           burst_left = 0;
  logic [CFG_W-1:0]             frustum [PLANE_REGS];

  always #5 clk = ~clk;

  view_frustum_cull_test_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type),
    .in_center_x(in_center_x), .in_center_y(in_center_y), .in_center_z(in_center_z),
    .in_extent_x(in_extent_x), .in_extent_y(in_extent_y), .in_extent_z(in_extent_z),
    .out_valid(out_valid), .out_inside_res(out_inside_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cull_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type),
    .in_center_x(in_center_x), .in_center_y(in_center_y), .in_center_z(in_center_z),
    .in_extent_x(in_extent_x), .in_extent_y(in_extent_y), .in_extent_z(in_extent_z),
    .out_valid(out_valid), .out_inside_res(out_inside_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("view_frustum_cull_test_core: mismatch");
      $finish;
    end
  end

  function automatic logic [CFG_W-1:0] pack_plane(int a, int b, int c, int d);
    return {d[D_W-1:0], c[CF_W-1:0], b[CF_W-1:0], a[CF_W-1:0]};
  endfunction

  function automatic int jit(int t);
    return int'($urandom_range(0, 2 * t)) - t;
  endfunction

  function automatic int rand_coord(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // axis-aligned box of half sizes hx, hy, hz around the origin, normals tilted a little
  task automatic build_box_frustum(int hx, int hy, int hz, int tilt);
    frustum[REG_RIGHT]  = pack_plane(-ONE + jit(tilt), jit(tilt), jit(tilt), hx * UNIT);
    frustum[REG_LEFT]   = pack_plane(ONE + jit(tilt), jit(tilt), jit(tilt), hx * UNIT);
    frustum[REG_BOTTOM] = pack_plane(jit(tilt), ONE + jit(tilt), jit(tilt), hy * UNIT);
    frustum[REG_TOP]    = pack_plane(jit(tilt), -ONE + jit(tilt), jit(tilt), hy * UNIT);
    frustum[REG_FAR]    = pack_plane(jit(tilt), jit(tilt), -ONE + jit(tilt), hz * UNIT);
    frustum[REG_NEAR]   = pack_plane(jit(tilt), jit(tilt), ONE + jit(tilt), hz * UNIT);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_frustum(bit spare);
    for (int i = 0; i < PLANE_REGS; i++) write_reg(i[CFG_IDX_W-1:0], frustum[i]);
    if (spare) begin
      write_reg(REG_SPARE_A, {$urandom, $urandom});
      write_reg(REG_SPARE_B, '1);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_query(logic [1:0] kind, int cx, int cy, int cz,
                            int ex, int ey, int ez);
    int gap, r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      r = $urandom_range(0, 9);
      gap = (r < 4) ? 0 : (r < 9) ? $urandom_range(1, 12) : $urandom_range(13, 45);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start       <= 1'b1;
    in_req_type <= kind;
    in_center_x <= cx[CRD_W-1:0];
    in_center_y <= cy[CRD_W-1:0];
    in_center_z <= cz[CRD_W-1:0];
    in_extent_x <= ex[EXT_W-1:0];
    in_extent_y <= ey[EXT_W-1:0];
    in_extent_z <= ez[EXT_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // wild requests use every bit of every field, the rest stay near the frustum
  task automatic send_random(int span, int ext_max, int wild_pct);
    int r;
    logic [1:0] kind;
    r = $urandom_range(0, 9);
    kind = (r < 3) ? REQ_POINT : (r < 6) ? REQ_SPHERE : (r < 9) ? REQ_BOX : REQ_BOX_ALT;
    if ($urandom_range(0, 99) < wild_pct)
      send_query(kind, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else
      send_query(kind, rand_coord(span), rand_coord(span), rand_coord(span),
                 $urandom_range(0, ext_max), $urandom_range(0, ext_max),
                 $urandom_range(0, ext_max));
  endtask

  initial begin
    int hx, hy, hz, span, ext_max, wild, r;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_req_type <= REQ_POINT;
    in_center_x <= '0;
    in_center_y <= '0;
    in_center_z <= '0;
    in_extent_x <= '0;
    in_extent_y <= '0;
    in_extent_z <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_RIGHT;
    cfg_data    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all planes zero after reset
    send_query(REQ_POINT, 0, 0, 0, 0, 0, 0);
    send_query(REQ_SPHERE, 0, 0, 0, 0, 0, 0);
    send_query(REQ_SPHERE, 5, -5, 9, 1, 0, 0);
    send_query(REQ_BOX, 0, 0, 0, 0, 0, 0);
    send_query(REQ_BOX_ALT, -3, 7, 11, 2, 4, 6);
    wait_idle();

    // cube frustum of half size 100, boundaries hit exactly
    build_box_frustum(100, 100, 100, 0);
    load_frustum(1'b1);
    send_query(REQ_POINT, 0, 0, 0, 0, 0, 0);
    send_query(REQ_POINT, 100 * UNIT, 0, 0, 0, 0, 0);
    send_query(REQ_POINT, 100 * UNIT - 1, -(100 * UNIT - 1), 100 * UNIT - 1, 0, 0, 0);
    send_query(REQ_SPHERE, 110 * UNIT, 0, 0, 10 * UNIT, 0, 0);
    send_query(REQ_SPHERE, 110 * UNIT, 0, 0, 10 * UNIT + 1, 0, 0);
    send_query(REQ_BOX, 150 * UNIT, 0, 0, 50 * UNIT, 0, 0);
    send_query(REQ_BOX, 150 * UNIT + 1, 0, 0, 50 * UNIT, 0, 0);
    send_query(REQ_BOX_ALT, 0, 0, -40000, 20000, 20000, 20000);
    send_query(REQ_BOX, 0, 0, 0, 8388607, 8388607, 8388607);
    send_query(REQ_POINT, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607);
    send_query(REQ_POINT, -8388608, -8388608, -8388608, 0, 0, 0);
    send_query(REQ_SPHERE, -8388608, -8388608, -8388608, 8388607, 0, 0);
    send_query(REQ_SPHERE, 8388607, 8388607, 8388607, 0, 8388607, 8388607);
    send_query(REQ_BOX, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607);
    send_query(REQ_BOX_ALT, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607);
    send_query(REQ_POINT, 0, 0, 0, 8388607, 8388607, 8388607);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      wild = 50;
      span = 4000000;
      ext_max = 8388607;
      case (ph)
        1: for (int i = 0; i < PLANE_REGS; i++) frustum[i] = {$urandom, $urandom};
        3: for (int i = 0; i < PLANE_REGS; i++) frustum[i] = pack_plane(2047, 2047, 2047, D_MAX);
        5: for (int i = 0; i < PLANE_REGS; i++)
             frustum[i] = pack_plane(-2048, -2048, -2048, D_MIN);
        7: begin
          for (int i = 0; i < PLANE_REGS; i++) begin
            r = $urandom_range(0, 3);
            frustum[i] = (r == 0) ? pack_plane(2047, 2047, 2047, D_MAX) :
                         (r == 1) ? pack_plane(-2048, -2048, -2048, D_MIN) :
                         (r == 2) ? '0 : {$urandom, $urandom};
          end
        end
        default: begin
          hx = $urandom_range(20, 2000);
          hy = $urandom_range(20, 2000);
          hz = $urandom_range(20, 2000);
          build_box_frustum(hx, hy, hz, $urandom_range(0, 200));
          span = ((hx > hy ? (hx > hz ? hx : hz) : (hy > hz ? hy : hz)) * UNIT * 3) / 2;
          ext_max = ((hx < hy ? (hx < hz ? hx : hz) : (hy < hz ? hy : hz)) * UNIT) / 2;
          wild = 10;
        end
      endcase
      load_frustum($urandom_range(0, 1));
      repeat (PHASE_ITEMS) send_random(span, ext_max, wild);
    end

    wait_idle();
    repeat (END_PAUSE) @(posedge clk);
    if (fail_count == 0)
      $display("view_frustum_cull_test_core: match");
    else
      $display("view_frustum_cull_test_core: mismatch");
    $finish;
  end

endmodule
